// ===== sv/radial_distance_remap_address_defines.svh =====
// Assertion macros for the radial distance remap address generator.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef RADIAL_DISTANCE_REMAP_ADDRESS_DEFINES_SVH
`define RADIAL_DISTANCE_REMAP_ADDRESS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RDRA_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("rdra: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RDRA_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("rdra: next-cycle check failed");

`endif

// ===== sv/rdra_pkg.sv =====
// Shared constants, types, root table and helpers for the remap address generator.
// No dependencies; imported by every module of the block.
package rdra_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int MAX_DIM     = 2048;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 2;
    localparam int COORD_W = 11;
    localparam int FRAC_W  = 8;
    localparam int SCALE_W = 24;
    localparam int DX_W    = 12;
    localparam int SQ_W    = 2 * DX_W;
    localparam int TERM_W  = 24;
    localparam int ROOT_W  = 12;
    localparam int V_W     = SCALE_W + DX_W;
    localparam int C_W     = V_W - FRAC_W + 1;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SUBPIXEL_MODE = 2'd2;

    localparam logic KIND_TABLE_WRITE = 1'b0;
    localparam logic KIND_PIXEL       = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic [DIM_W-1:0] size;
        logic [DIM_W-1:0] half;
    } axis_cfg_t;

    localparam logic [7:0] ROOT_LUT [256] = '{
        8'd0,   8'd16,  8'd22,  8'd27,  8'd32,  8'd35,  8'd39,  8'd42,
        8'd45,  8'd48,  8'd50,  8'd53,  8'd55,  8'd57,  8'd59,  8'd61,
        8'd64,  8'd65,  8'd67,  8'd69,  8'd71,  8'd73,  8'd75,  8'd76,
        8'd78,  8'd80,  8'd81,  8'd83,  8'd84,  8'd86,  8'd87,  8'd89,
        8'd90,  8'd91,  8'd93,  8'd94,  8'd96,  8'd97,  8'd98,  8'd99,
        8'd101, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd109,
        8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118,
        8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126,
        8'd128, 8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134,
        8'd135, 8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142,
        8'd143, 8'd144, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149,
        8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd155,
        8'd156, 8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162,
        8'd163, 8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd167, 8'd168,
        8'd169, 8'd170, 8'd170, 8'd171, 8'd172, 8'd173, 8'd173, 8'd174,
        8'd175, 8'd176, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179, 8'd180,
        8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd185,
        8'd186, 8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191,
        8'd192, 8'd192, 8'd193, 8'd193, 8'd194, 8'd195, 8'd195, 8'd196,
        8'd197, 8'd197, 8'd198, 8'd199, 8'd199, 8'd200, 8'd201, 8'd201,
        8'd202, 8'd203, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206, 8'd206,
        8'd207, 8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd211, 8'd211,
        8'd212, 8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216,
        8'd217, 8'd217, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd221,
        8'd221, 8'd222, 8'd222, 8'd223, 8'd224, 8'd224, 8'd225, 8'd225,
        8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd229, 8'd229, 8'd230,
        8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234,
        8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238,
        8'd239, 8'd240, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243,
        8'd243, 8'd244, 8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247,
        8'd247, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251,
        8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255
    };

    function automatic axis_cfg_t make_axis(input logic [CFG_W-1:0] raw);
        logic [DIM_W-1:0] size;
        axis_cfg_t        axis;
        if (raw < CFG_W'(2)) begin
            size = DIM_W'(2);
        end else if (32'(raw) > MAX_DIM) begin
            size = DIM_W'(MAX_DIM);
        end else begin
            size = DIM_W'(raw);
        end
        axis.size = size;
        axis.half = size >> 1;
        return axis;
    endfunction

endpackage

// ===== sv/rdra_root.sv =====
// Approximate square root of the distance term: range select, root table, shift, saturate.
// Combinational; depends on rdra_pkg for the root table and widths.
module rdra_root import rdra_pkg::*; (
    input  logic [TERM_W-1:0] term,
    output logic [ADDR_W-1:0] addr
);

    logic [ROOT_W-1:0] root;

    // Term is at least 256 by construction, so the lowest range is the last arm.
    always_comb begin
        priority if (term >= TERM_W'(24'h400000)) begin
            root = {ROOT_LUT[term[23:16]], 4'b0};
        end else if (term >= TERM_W'(24'h100000)) begin
            root = {1'b0, ROOT_LUT[term[21:14]], 3'b0};
        end else if (term >= TERM_W'(24'h040000)) begin
            root = {2'b0, ROOT_LUT[term[19:12]], 2'b0};
        end else if (term >= TERM_W'(24'h010000)) begin
            root = {3'b0, ROOT_LUT[term[17:10]], 1'b0};
        end else if (term >= TERM_W'(24'h004000)) begin
            root = {4'b0, ROOT_LUT[term[15:8]]};
        end else if (term >= TERM_W'(24'h001000)) begin
            root = {5'b0, ROOT_LUT[term[13:6]][7:1]};
        end else if (term >= TERM_W'(24'h000400)) begin
            root = {6'b0, ROOT_LUT[term[11:4]][7:2]};
        end else begin
            root = {7'b0, ROOT_LUT[term[9:2]][7:3]};
        end
    end

    always_comb begin
        if (32'(root) >= TABLE_DEPTH) begin
            addr = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            addr = ADDR_W'(root);
        end
    end

endmodule

// ===== sv/rdra_scale_ram.sv =====
// Scale table storage: one write port and one registered read port.
// Depends on rdra_pkg for depth and entry width.
module rdra_scale_ram import rdra_pkg::*; (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [SCALE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic signed [SCALE_W-1:0] rd_data
);

    logic signed [SCALE_W-1:0] mem [TABLE_DEPTH];
    logic signed [SCALE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/rdra_coord.sv =====
// Source coordinate for one axis: rounded shift, recentre, clamp, fraction.
// Combinational; depends on rdra_pkg for widths and the axis config type.
module rdra_coord import rdra_pkg::*; (
    input  logic signed [V_W-1:0] v,
    input  axis_cfg_t             axis,
    input  logic                  subpixel,
    output logic [COORD_W-1:0]    coord,
    output logic [FRAC_W-1:0]     frac
);

    logic signed [C_W-1:0] c;
    logic [DIM_W-1:0]      lim;
    logic [DIM_W-1:0]      lim_m1;

    always_comb begin
        c      = $signed({v[V_W-1], v[V_W-1:FRAC_W]}) + $signed(C_W'(axis.half));
        lim    = subpixel ? axis.size - DIM_W'(1) : axis.size;
        lim_m1 = lim - DIM_W'(1);
        priority if (c[C_W-1]) begin
            coord = '0;
        end else if (c >= $signed(C_W'(lim))) begin
            coord = COORD_W'(lim_m1);
        end else begin
            coord = c[COORD_W-1:0];
        end
        frac = subpixel ? v[FRAC_W-1:0] : '0;
    end

endmodule

// ===== sv/radial_distance_remap_address.sv =====
// Channel  | Handshake          | Payload
// s_       | s_valid / s_ready  | kind, entry_index, entry_value, pixel_col, pixel_row
// m_       | m_valid / m_ready  | source_col, source_row, frac_col, frac_row
// cfg_     | cfg_wr_en          | cfg_wr_index, cfg_wr_data (no read-back)
//
// One item per clock unless m_ready holds the pipeline back; a pixel item passes through every stage below to m_.
// Stages: offset, square, term, root, scale table read, multiply, clamp.
// Table-write items write at the table read stage and leave no result.
// Synchronous active-low reset clears valid bits and sets config to its reset values; table is unset.
// Each stage holds only when it is full and the next one cannot take its item.
module radial_distance_remap_address import rdra_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [IDX_W-1:0]          cfg_wr_index,
    input  logic [CFG_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [10:0]               s_entry_index,
    input  logic signed [SCALE_W-1:0] s_entry_value,
    input  logic [10:0]               s_pixel_col,
    input  logic [10:0]               s_pixel_row,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [COORD_W-1:0]        m_source_col,
    output logic [COORD_W-1:0]        m_source_row,
    output logic [FRAC_W-1:0]         m_frac_col,
    output logic [FRAC_W-1:0]         m_frac_row
);

`include "radial_distance_remap_address_defines.svh"

    axis_cfg_t width_cfg_reg;
    axis_cfg_t height_cfg_reg;
    logic      subpixel_reg;

    logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, m_valid_reg;

    logic                      kind1_reg, kind2_reg, kind3_reg, kind4_reg;
    logic [10:0]               idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [SCALE_W-1:0] val1_reg, val2_reg, val3_reg, val4_reg;

    logic signed [DX_W-1:0]   dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [DX_W-1:0]   dx4_reg, dy4_reg, dx5_reg, dy5_reg;
    logic signed [SQ_W-1:0]   sqx2_reg, sqy2_reg;
    logic [TERM_W-1:0]        term3_reg;
    logic [TERM_W-1:0]        term_next;
    logic [ADDR_W-1:0]        root_addr;
    logic [ADDR_W-1:0]        addr4_reg;
    logic signed [SCALE_W-1:0] scale5;
    logic signed [V_W-1:0]    vx6_reg, vy6_reg;

    logic                     ram_wr_en;
    logic [COORD_W-1:0]       col_next, row_next;
    logic [FRAC_W-1:0]        fcol_next, frow_next;
    logic [COORD_W-1:0]       m_source_col_reg, m_source_row_reg;
    logic [FRAC_W-1:0]        m_frac_col_reg, m_frac_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= make_axis(WIDTH_RESET);
            height_cfg_reg <= make_axis(HEIGHT_RESET);
            subpixel_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FRAME_WIDTH:   width_cfg_reg  <= make_axis(cfg_wr_data);
                REG_FRAME_HEIGHT:  height_cfg_reg <= make_axis(cfg_wr_data);
                REG_SUBPIXEL_MODE: subpixel_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign adv7    = !m_valid_reg || m_ready;
    assign adv6    = !v6_reg || adv7;
    assign adv5    = !v5_reg || adv6;
    assign adv4    = !v4_reg || adv5;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg && (kind4_reg == KIND_PIXEL);
            if (adv6) v6_reg <= v5_reg;
            if (adv7) m_valid_reg <= v6_reg;
        end
    end

    // Offset from centre
    always_ff @(posedge aclk) begin
        if (adv1) begin
            kind1_reg <= s_kind;
            idx1_reg  <= s_entry_index;
            val1_reg  <= s_entry_value;
            dx1_reg   <= $signed(DX_W'(s_pixel_col) - DX_W'(width_cfg_reg.half));
            dy1_reg   <= $signed(DX_W'(s_pixel_row) - DX_W'(height_cfg_reg.half));
        end
    end

    // Squares
    always_ff @(posedge aclk) begin
        if (adv2) begin
            kind2_reg <= kind1_reg;
            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            sqx2_reg  <= dx1_reg * dx1_reg;
            sqy2_reg  <= dy1_reg * dy1_reg;
        end
    end

    // Distance term, always positive and below 2^24
    assign term_next = TERM_W'(sqx2_reg) - TERM_W'(dx2_reg)
                     + TERM_W'(sqy2_reg) + TERM_W'(256);

    always_ff @(posedge aclk) begin
        if (adv3) begin
            kind3_reg <= kind2_reg;
            idx3_reg  <= idx2_reg;
            val3_reg  <= val2_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            term3_reg <= term_next;
        end
    end

    rdra_root u_root (
        .term (term3_reg),
        .addr (root_addr)
    );

    always_ff @(posedge aclk) begin
        if (adv4) begin
            kind4_reg <= kind3_reg;
            idx4_reg  <= idx3_reg;
            val4_reg  <= val3_reg;
            dx4_reg   <= dx3_reg;
            dy4_reg   <= dy3_reg;
            addr4_reg <= root_addr;
        end
    end

    // Table writes take effect in item order at this stage
    assign ram_wr_en = adv5 && v4_reg && (kind4_reg == KIND_TABLE_WRITE)
                    && (32'(idx4_reg) < TABLE_DEPTH);

    rdra_scale_ram u_scale_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(idx4_reg)),
        .wr_data (val4_reg),
        .rd_en   (adv5),
        .rd_addr (addr4_reg),
        .rd_data (scale5)
    );

    always_ff @(posedge aclk) begin
        if (adv5) begin
            dx5_reg <= dx4_reg;
            dy5_reg <= dy4_reg;
        end
    end

    // Scaled offsets with rounding bias
    always_ff @(posedge aclk) begin
        if (adv6) begin
            vx6_reg <= V_W'(scale5) * V_W'(dx5_reg) + V_W'(128);
            vy6_reg <= V_W'(scale5) * V_W'(dy5_reg) + V_W'(128);
        end
    end

    rdra_coord u_coord_col (
        .v        (vx6_reg),
        .axis     (width_cfg_reg),
        .subpixel (subpixel_reg),
        .coord    (col_next),
        .frac     (fcol_next)
    );

    rdra_coord u_coord_row (
        .v        (vy6_reg),
        .axis     (height_cfg_reg),
        .subpixel (subpixel_reg),
        .coord    (row_next),
        .frac     (frow_next)
    );

    always_ff @(posedge aclk) begin
        if (adv7) begin
            m_source_col_reg <= col_next;
            m_source_row_reg <= row_next;
            m_frac_col_reg   <= fcol_next;
            m_frac_row_reg   <= frow_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_source_col = m_source_col_reg;
    assign m_source_row = m_source_row_reg;
    assign m_frac_col   = m_frac_col_reg;
    assign m_frac_row   = m_frac_row_reg;

    `RDRA_ASSERT_NOW(a_frac_zero, m_valid && !subpixel_reg, (m_frac_col == '0) && (m_frac_row == '0))
    `RDRA_ASSERT_NOW(a_col_in_frame, m_valid, DIM_W'(m_source_col) < width_cfg_reg.size)
    `RDRA_ASSERT_NOW(a_root_in_table, v4_reg, 32'(addr4_reg) < TABLE_DEPTH)
    `RDRA_ASSERT_NEXT(a_write_no_result, adv5 && v4_reg && (kind4_reg == KIND_TABLE_WRITE), !v5_reg)

endmodule
